// File: rtl/rcpb_pkg.sv
// Shared types and constants for the ray clip point-to-box block.
`timescale 1ns / 1ps
package rcpb_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int CFG_INDEX_W = 8;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_X_MIN = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_X_MAX = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_Y_MIN = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_Y_MAX = 8'd3;

  // status codes
  localparam logic [1:0] ST_CLIPPED  = 2'd0;
  localparam logic [1:0] ST_INSIDE   = 2'd1;
  localparam logic [1:0] ST_ZERO_DIV = 2'd2;

  // per-item data that rides alongside the divider
  typedef struct packed {
    logic               xout;
    logic               yout;
    logic               zero;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] xlim;
    logic signed [31:0] ylim;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
  } sb_t;

endpackage

// File: rtl/rcpb_div.sv
// Pipelined restoring fraction divider, one quotient bit per stage, saturating.
`timescale 1ns / 1ps
module rcpb_div #(
  parameter int COORD_FRAC_BITS = rcpb_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [31:0]                a,
  input  logic [31:0]                b,
  output logic [COORD_FRAC_BITS-1:0] q
);
  import rcpb_pkg::*;

  localparam int F = COORD_FRAC_BITS;

  logic [31:0]  r_q   [F];
  logic [31:0]  b_q   [F];
  logic [F-1:0] q_q   [F];
  logic         sat_q [F];

  logic [31:0]  rin   [F];
  logic [31:0]  bin   [F];
  logic [F-1:0] qin   [F];
  logic         satin [F];

  for (genvar k = 0; k < F; k++) begin : g_stage
    logic [32:0] s;
    logic        ge;
    if (k == 0) begin : g_first
      assign rin[k]   = a;
      assign bin[k]   = b;
      assign qin[k]   = '0;
      // a >= b means the fraction reaches one: clamp
      assign satin[k] = (a >= b);
    end else begin : g_next
      assign rin[k]   = r_q[k-1];
      assign bin[k]   = b_q[k-1];
      assign qin[k]   = q_q[k-1];
      assign satin[k] = sat_q[k-1];
    end
    assign s  = {rin[k], 1'b0};
    assign ge = (s >= {1'b0, bin[k]});
    always_ff @(posedge clk) begin
      if (en) begin
        r_q[k]   <= ge ? 32'(s - {1'b0, bin[k]}) : s[31:0];
        b_q[k]   <= bin[k];
        q_q[k]   <= {qin[k][F-2:0], ge};
        sat_q[k] <= satin[k];
      end
    end
  end

  assign q = sat_q[F-1] ? {F{1'b1}} : q_q[F-1];

endmodule

// File: rtl/rcpb_lerp.sv
// Interpolation c + t*d: registered multiply, then rounding, add and saturation.
`timescale 1ns / 1ps
module rcpb_lerp #(
  parameter int COORD_FRAC_BITS = rcpb_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [COORD_FRAC_BITS-1:0] t,
  input  logic signed [31:0]         c,
  input  logic signed [32:0]         d,
  output logic signed [31:0]         res
);
  import rcpb_pkg::*;

  localparam int F  = COORD_FRAC_BITS;
  localparam int PW = F + 34;
  localparam logic signed [PW-1:0] HALF = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [34:0] MAXV = 35'sd2147483647;
  localparam logic signed [34:0] MINV = -35'sd2147483648;

  logic signed [PW-1:0] prod;
  logic signed [31:0]   c_q;
  logic signed [PW-1:0] v;
  logic signed [PW-F-1:0] qv;
  logic signed [34:0]   sum;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PW'($signed({1'b0, t}) * d);
      c_q  <= c;
    end
  end

  // arithmetic shift floors, so ties go toward +infinity
  always_comb begin
    v   = prod + HALF;
    qv  = (PW-F)'(v >>> F);
    sum = 35'(c_q) + 35'(qv);
    if (sum > MAXV)      res = 32'sh7FFFFFFF;
    else if (sum < MINV) res = 32'sh80000000;
    else                 res = sum[31:0];
  end

endmodule

// File: rtl/ray_clip_point_to_box.sv
// Top level of the ray clip point-to-box pipeline.
`timescale 1ns / 1ps
// Pulls a target point back along the ray from a centre point onto the border of a
// configured axis-aligned box (signed Q16.16 by default). One point enters per cycle
// and its result passes through two prep stages, one divider stage per fraction bit,
// a fraction select stage, a multiply stage and the output register.
// The whole pipe stalls as one while a result waits on m_tready.
// status: 0 clipped, 1 target inside the box, 2 zero divisor (points read 0 for 1 and 2).
// Box registers are written over the cfg channel, which is always ready.
module ray_clip_point_to_box #(
  parameter int COORD_FRAC_BITS = rcpb_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // centre_x, centre_y, target_x, target_y
  input  logic [127:0]                     s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // clipped_x, clipped_y
  output logic [63:0]                      m_tdata,
  // status
  output logic [1:0]                       m_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rcpb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data
);
  import rcpb_pkg::*;

  localparam int F   = COORD_FRAC_BITS;
  localparam int LAT = F + 5;

  logic signed [31:0] box_x_min, box_x_max, box_y_min, box_y_max;
  logic [LAT-1:0] vld;
  logic en;

  // box registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      box_x_min <= '0;
      box_x_max <= '0;
      box_y_min <= '0;
      box_y_max <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BOX_X_MIN: box_x_min <= cfg_data;
        REG_BOX_X_MAX: box_x_max <= cfg_data;
        REG_BOX_Y_MIN: box_y_min <= cfg_data;
        REG_BOX_Y_MAX: box_y_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // one enable for every stage
  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // stage 1: limit tests and differences
  logic signed [31:0] in_cx, in_cy, in_px, in_py;
  logic xout_c, yout_c;
  logic signed [31:0] xlim_c, ylim_c;
  sb_t sb1;
  logic signed [32:0] nx1, ny1;

  assign in_cx = s_tdata[31:0];
  assign in_cy = s_tdata[63:32];
  assign in_px = s_tdata[95:64];
  assign in_py = s_tdata[127:96];

  always_comb begin
    xout_c = 1'b1;
    xlim_c = box_x_max;
    if (in_px > box_x_max) xlim_c = box_x_max;
    else if (in_px < box_x_min) xlim_c = box_x_min;
    else xout_c = 1'b0;
    yout_c = 1'b1;
    ylim_c = box_y_max;
    if (in_py > box_y_max) ylim_c = box_y_max;
    else if (in_py < box_y_min) ylim_c = box_y_min;
    else yout_c = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb1.xout <= xout_c;
      sb1.yout <= yout_c;
      sb1.zero <= 1'b0;
      sb1.cx   <= in_cx;
      sb1.cy   <= in_cy;
      sb1.xlim <= xlim_c;
      sb1.ylim <= ylim_c;
      sb1.dx   <= 33'(in_px) - 33'(in_cx);
      sb1.dy   <= 33'(in_py) - 33'(in_cy);
      nx1      <= 33'(xlim_c) - 33'(in_cx);
      ny1      <= 33'(ylim_c) - 33'(in_cy);
    end
  end

  // stage 2: magnitudes; opposite signs or a zero numerator give t = 0
  sb_t sb_d [F+1];
  sb_t sb2_c;
  logic [31:0] anx, adx, any_q, ady;
  logic mis_x, mis_y;
  logic [32:0] nxa, dxa, nya, dya;

  always_comb begin
    mis_x = (nx1 == '0) || (nx1[32] != sb1.dx[32]);
    mis_y = (ny1 == '0) || (ny1[32] != sb1.dy[32]);
    nxa   = nx1[32] ? 33'(-nx1) : nx1;
    dxa   = sb1.dx[32] ? 33'(-sb1.dx) : sb1.dx;
    nya   = ny1[32] ? 33'(-ny1) : ny1;
    dya   = sb1.dy[32] ? 33'(-sb1.dy) : sb1.dy;
    // a needed fraction with a zero divisor
    sb2_c      = sb1;
    sb2_c.zero = (sb1.xout && sb1.dx == '0) || (sb1.yout && sb1.dy == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_d[0]      <= sb2_c;
      anx          <= mis_x ? '0 : nxa[31:0];
      adx          <= dxa[31:0];
      any_q        <= mis_y ? '0 : nya[31:0];
      ady          <= dya[31:0];
      for (int k = 1; k <= F; k++) sb_d[k] <= sb_d[k-1];
    end
  end

  // fraction dividers, F stages each
  logic [F-1:0] tx, ty;

  rcpb_div #(.COORD_FRAC_BITS(F)) u_div_x (
    .clk(clk), .en(en), .a(anx), .b(adx), .q(tx)
  );
  rcpb_div #(.COORD_FRAC_BITS(F)) u_div_y (
    .clk(clk), .en(en), .a(any_q), .b(ady), .q(ty)
  );

  // select stage: corner takes the smaller fraction
  sb_t sb3, sb4;
  logic [F-1:0] t3;
  always_ff @(posedge clk) begin
    if (en) begin
      sb3 <= sb_d[F];
      if (sb_d[F].xout && sb_d[F].yout) t3 <= (tx < ty) ? tx : ty;
      else if (sb_d[F].xout)            t3 <= tx;
      else                              t3 <= ty;
      sb4 <= sb3;
    end
  end

  // multiply stage (inside the lerp units)
  logic signed [31:0] lx, ly;
  rcpb_lerp #(.COORD_FRAC_BITS(F)) u_lerp_x (
    .clk(clk), .en(en), .t(t3), .c(sb3.cx), .d(sb3.dx), .res(lx)
  );
  rcpb_lerp #(.COORD_FRAC_BITS(F)) u_lerp_y (
    .clk(clk), .en(en), .t(t3), .c(sb3.cy), .d(sb3.dy), .res(ly)
  );

  // output register; when only one axis is crossed, that axis lands exactly on its limit
  logic [1:0] st_c;
  always_comb begin
    if (sb4.zero)                  st_c = ST_ZERO_DIV;
    else if (!sb4.xout && !sb4.yout) st_c = ST_INSIDE;
    else                           st_c = ST_CLIPPED;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= st_c;
      if (st_c != ST_CLIPPED) begin
        m_tdata <= '0;
      end else begin
        m_tdata[31:0]  <= (sb4.xout && !sb4.yout) ? sb4.xlim : lx;
        m_tdata[63:32] <= (sb4.yout && !sb4.xout) ? sb4.ylim : ly;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_bad_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser != 2'd3))
    else $error("invalid status code");
  a_err_zero_point: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_INSIDE || m_tuser == ST_ZERO_DIV)) |-> (m_tdata == '0))
    else $error("error result carries nonzero point");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");
`endif

endmodule
